@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/sli_pkg.sv @@
`default_nettype none

package sli_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OUT_CNT_W    = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EXEC,
    S_PUT
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [OUT_CNT_W-1:0]     count_out;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

@@ rtl/core/sli_cmp.sv @@
`default_nettype none

module sli_cmp (
  input  logic signed [sli_pkg::DATA_W-1:0] a_i,
  input  logic signed [sli_pkg::DATA_W-1:0] b_i,
  output sli_pkg::cmp_t                     cmp_o
);
  import sli_pkg::*;

  always_comb begin
    cmp_o.lt = (a_i < b_i);
    cmp_o.eq = (a_i == b_i);
  end

endmodule

`default_nettype wire

@@ rtl/core/sorted_list_insert_delete_core.sv @@
// Each visited list entry takes a memory read (S_RD) and then a compare/move (S_EXEC).
// Insert walks down from the top over the entries not less than the value, moving each
// up one slot; a value that lands at the head is written in S_PUT. A full or empty list
// answers straight from idle. Delete walks the whole list. Dump gives one beat per entry.
// Paced by the list memory (one access at a time) and one shared comparator; receiver cannot stall.
// Reset clears the entry count and sequencer; list memory is not cleared.
`default_nettype none

module sorted_list_insert_delete_core #(
  parameter int unsigned CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sli_pkg::in_t   in_i,
  output logic           busy_o,
  output logic           res_strobe_o,
  output sli_pkg::out_t  res_o
);
  import sli_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [1:0]               kind_q, kind_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     found_q, found_d;
  logic signed [DATA_W-1:0] rdata_q;
  out_t                     res_q, res_d;
  logic                     strobe_q, strobe_d;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic                     we, re;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;

  logic [CW-1:0]            idx_nxt, idx_prv;
  logic                     last_idx;
  cmp_t                     cmp;

  sli_cmp u_cmp (
    .a_i   (rdata_q),
    .b_i   (val_q),
    .cmp_o (cmp)
  );

  assign idx_nxt  = idx_q + CW'(1);
  assign idx_prv  = idx_q - CW'(1);
  assign last_idx = (idx_q == count_q - CW'(1));

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    kind_d   = kind_q;
    val_d    = val_q;
    found_d  = found_q;
    res_d    = '0;
    strobe_d = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx_q[AW-1:0];
    wdata    = rdata_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d  = in_i.kind;
          val_d   = in_i.value;
          found_d = 1'b0;
          unique case (kind_e'(in_i.kind))
            KIND_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
                res_d.last   = 1'b1;
                strobe_d     = 1'b1;
              end else if (count_q == '0) begin
                we           = 1'b1;
                waddr        = '0;
                wdata        = in_i.value;
                count_d      = CW'(1);
                res_d.status = ST_OK;
                res_d.last   = 1'b1;
                strobe_d     = 1'b1;
              end else begin
                idx_d   = count_q - CW'(1);
                state_d = S_RD;
              end
            end
            KIND_DELETE: begin
              if (count_q == '0) begin
                res_d.status = ST_NOT_FOUND;
                res_d.last   = 1'b1;
                strobe_d     = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_RD;
              end
            end
            KIND_DUMP: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                res_d.last   = 1'b1;
                strobe_d     = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_RD;
              end
            end
            default: begin
              res_d.status = ST_OK;
              res_d.last   = 1'b1;
              strobe_d     = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        re      = 1'b1;
        state_d = S_EXEC;
      end

      S_EXEC: begin
        unique case (kind_e'(kind_q))
          KIND_INSERT: begin
            we    = 1'b1;
            waddr = idx_nxt[AW-1:0];
            if (cmp.lt) begin
              wdata        = val_q;
              count_d      = count_q + CW'(1);
              res_d.status = ST_OK;
              res_d.last   = 1'b1;
              strobe_d     = 1'b1;
              state_d      = S_IDLE;
            end else begin
              wdata = rdata_q;
              if (idx_q == '0) begin
                state_d = S_PUT;
              end else begin
                idx_d   = idx_prv;
                state_d = S_RD;
              end
            end
          end
          KIND_DELETE: begin
            found_d = found_q | cmp.eq;
            if (found_q) begin
              we    = 1'b1;
              waddr = idx_prv[AW-1:0];
              wdata = rdata_q;
            end
            if (last_idx) begin
              if (found_d) begin
                count_d      = count_q - CW'(1);
                res_d.status = ST_OK;
              end else begin
                res_d.status = ST_NOT_FOUND;
              end
              res_d.last = 1'b1;
              strobe_d   = 1'b1;
              state_d    = S_IDLE;
            end else begin
              idx_d   = idx_nxt;
              state_d = S_RD;
            end
          end
          KIND_DUMP: begin
            res_d.data_out = rdata_q;
            res_d.status   = ST_OK;
            res_d.last     = last_idx;
            strobe_d       = 1'b1;
            if (last_idx) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_nxt;
              state_d = S_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        we           = 1'b1;
        waddr        = '0;
        wdata        = val_q;
        count_d      = count_q + CW'(1);
        res_d.status = ST_OK;
        res_d.last   = 1'b1;
        strobe_d     = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count_out = OUT_CNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    kind_q  <= kind_d;
    val_q   <= val_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  // list memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  `SLI_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `SLI_ASSERT(a_accept_acts, start_i && !busy_o |=> busy_o || res_strobe_o, "accepted item lost")
  `SLI_ASSERT(a_dump_mid_busy, res_strobe_o && !res_o.last |-> busy_o, "dump beat left idle")
  `SLI_ASSERT(a_count_out, res_strobe_o |-> res_o.count_out == OUT_CNT_W'(count_q), "count mismatch")

endmodule

`default_nettype wire

@@ test/sorted_list_insert_delete_core_test.sv @@
`default_nettype none

module sorted_list_insert_delete_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 4 * CAP + 20;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    in_t beat;
    int unsigned idle_pct;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  in_t in_i = '0;
  logic busy_o;
  logic res_strobe_o;
  out_t res_o;

  pending_t pending_beats[$];
  out_t expected_results[$];
  logic signed [DATA_W-1:0] list_model[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  sorted_list_insert_delete_core #(.CAPACITY(CAP)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .in_i(in_i),
    .busy_o(busy_o),
    .res_strobe_o(res_strobe_o),
    .res_o(res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_t make_result(logic signed [DATA_W-1:0] data, status_e st,
                                       logic last);
    out_t r;
    r.data_out = data;
    r.status = st;
    r.count_out = OUT_CNT_W'(list_model.size());
    r.last = last;
    return r;
  endfunction

  // Updates the list model and queues the beats this operation produces.
  function automatic void predict_list_op(in_t beat);
    int unsigned n;
    int unsigned pos;
    n = list_model.size();
    pos = 0;
    case (beat.kind)
      KIND_INSERT: begin
        if (n >= CAP) begin
          expected_results.push_back(make_result('0, ST_FULL, 1'b1));
        end else begin
          while (pos < n && list_model[pos] < beat.value) pos++;
          list_model.insert(pos, beat.value);
          expected_results.push_back(make_result('0, ST_OK, 1'b1));
        end
      end
      KIND_DELETE: begin
        while (pos < n && list_model[pos] != beat.value) pos++;
        if (pos >= n) begin
          expected_results.push_back(make_result('0, ST_NOT_FOUND, 1'b1));
        end else begin
          list_model.delete(pos);
          expected_results.push_back(make_result('0, ST_OK, 1'b1));
        end
      end
      KIND_DUMP: begin
        if (n == 0) begin
          expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
        end else begin
          for (int unsigned i = 0; i < n; i++)
            expected_results.push_back(make_result(list_model[i], ST_OK, i + 1 == n));
        end
      end
      default: begin
        expected_results.push_back(make_result('0, ST_OK, 1'b1));
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) predict_list_op(in_i);
      if (!start_i || !busy_o) begin
        if (pending_beats.size() != 0 &&
            $urandom_range(99) >= pending_beats[0].idle_pct) begin
          in_i <= pending_beats[0].beat;
          start_i <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && res_strobe_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: data_out %0d status %0d count_out %0d last %0b",
               res_o.data_out, res_o.status, res_o.count_out, res_o.last);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (res_o.data_out !== exp_r.data_out) begin
          $error("data_out: expected %0d, got %0d", exp_r.data_out, res_o.data_out);
          mismatches++;
        end
        if (res_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, res_o.status);
          mismatches++;
        end
        if (res_o.count_out !== exp_r.count_out) begin
          $error("count_out: expected %0d, got %0d", exp_r.count_out, res_o.count_out);
          mismatches++;
        end
        if (res_o.last !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, res_o.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void add_beat(logic [1:0] kind, logic signed [DATA_W-1:0] value,
                                   int unsigned idle_pct);
    pending_t p;
    p.beat.kind = kind;
    p.beat.value = value;
    p.idle_pct = idle_pct;
    pending_beats.push_back(p);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(
      logic signed [DATA_W-1:0] pool[6], int unsigned pool_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < pool_pct) return pool[$urandom_range(5)];
    if (r < pool_pct + 8) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    logic signed [DATA_W-1:0] pool[6];
    int unsigned idle_by_phase[4];
    int unsigned idle;
    int unsigned r;
    int unsigned ins_pct;
    bit filling;

    idle_by_phase = '{0, 68, 0, 21};

    // directed: empty-list cases, extremes, duplicates, fill past capacity
    add_beat(KIND_DUMP, 32'sd5, 0);
    add_beat(KIND_DELETE, 32'sd5, 0);
    add_beat(KIND_UNUSED, VAL_MAX, 0);
    add_beat(KIND_INSERT, 32'sd0, 0);
    add_beat(KIND_INSERT, VAL_MAX, 0);
    add_beat(KIND_INSERT, VAL_MIN, 0);
    add_beat(KIND_INSERT, -32'sd1, 0);
    add_beat(KIND_INSERT, 32'sd0, 0);
    add_beat(KIND_DELETE, 32'sd42, 0);
    add_beat(KIND_DELETE, 32'sd0, 0);
    add_beat(KIND_DUMP, VAL_MIN, 0);
    for (int i = 0; i < 12; i++) add_beat(KIND_INSERT, $urandom, 0);
    add_beat(KIND_INSERT, 32'sd7, 0);
    add_beat(KIND_DUMP, '0, 0);
    add_beat(KIND_DELETE, VAL_MIN, 0);
    add_beat(KIND_DELETE, VAL_MAX, 0);

    // random: alternating fill and drain stretches over a small value pool
    filling = 1'b1;
    for (int i = 0; i < 310; i++) begin
      if (i % 60 == 0) begin
        for (int k = 0; k < 6; k++) pool[k] = ($urandom_range(1)) ? $urandom :
                                                $signed($urandom_range(20)) - 10;
      end
      if (i % 30 == 0) filling = !filling || ($urandom_range(3) == 0);
      idle = idle_by_phase[(i / 78) % 4];
      ins_pct = filling ? 62 : 20;
      r = $urandom_range(99);
      if (r < ins_pct)
        add_beat(KIND_INSERT, pick_value(pool, 55), idle);
      else if (r < 82)
        add_beat(KIND_DELETE, pick_value(pool, 70), idle);
      else if (r < 96)
        add_beat(KIND_DUMP, $urandom, idle);
      else
        add_beat(KIND_UNUSED, $urandom, idle);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_beats.size() != 0 || start_i || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_cmp.sv
rtl/core/sorted_list_insert_delete_core.sv
test/sorted_list_insert_delete_core_test.sv
